### design/trct_pkg.sv
// trct_pkg: shared constants and codes for the transport receive connection table
// field widths, command / segment / reply / status / link state codes, parameter defaults
// no dependencies

package trct_pkg;

   // parameter defaults
   localparam int SLOTS_DEFAULT        = 16;
   localparam int BUFFER_BYTES_DEFAULT = 65536;

   // field widths
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 4;
   localparam int PORT_W   = 16;
   localparam int NODE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int SEQ_W    = 32;
   localparam int CNT_W    = 17;
   localparam int REPLY_W  = 2;
   localparam int STATUS_W = 3;
   localparam int LINK_W   = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEGMENT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd3;

   // segment kinds
   localparam logic [KIND_W-1:0] SEG_SYN   = 2'd0;
   localparam logic [KIND_W-1:0] SEG_FIN   = 2'd1;
   localparam logic [KIND_W-1:0] SEG_DATA  = 2'd2;
   localparam logic [KIND_W-1:0] SEG_OTHER = 2'd3;

   // reply kinds
   localparam logic [REPLY_W-1:0] RK_NONE    = 2'd0;
   localparam logic [REPLY_W-1:0] RK_SYNACK  = 2'd1;
   localparam logic [REPLY_W-1:0] RK_FINACK  = 2'd2;
   localparam logic [REPLY_W-1:0] RK_DATAACK = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_MATCH       = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BUF_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OUT_OF_ORDER   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_SLOT_EMPTY     = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_NOT_CLOSE_WAIT = 3'd6;

   // link states
   localparam logic [LINK_W-1:0] LINK_CLOSED     = 2'd0;
   localparam logic [LINK_W-1:0] LINK_CONNECTED  = 2'd1;
   localparam logic [LINK_W-1:0] LINK_CLOSE_WAIT = 2'd2;

endpackage

### design/trct_if.sv
// trct_req_if / trct_rsp_if: valid/ready channels for commands and replies
// depends on trct_pkg for field widths

interface trct_req_if;
   logic                             valid;
   logic                             ready;
   logic [trct_pkg::CMD_W-1:0]       cmd;
   logic [trct_pkg::SLOT_W-1:0]      slot;
   logic [trct_pkg::PORT_W-1:0]      local_port;
   logic [trct_pkg::PORT_W-1:0]      remote_port;
   logic [trct_pkg::NODE_W-1:0]      source_node;
   logic [trct_pkg::KIND_W-1:0]      segment_kind;
   logic [trct_pkg::SEQ_W-1:0]       sequence_req;
   logic [trct_pkg::CNT_W-1:0]       byte_count;

   modport source (output valid, cmd, slot, local_port, remote_port, source_node,
                   segment_kind, sequence_req, byte_count, input ready);
   modport sink   (input valid, cmd, slot, local_port, remote_port, source_node,
                   segment_kind, sequence_req, byte_count, output ready);
endinterface

interface trct_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [trct_pkg::REPLY_W-1:0]     reply_kind;
   logic [trct_pkg::PORT_W-1:0]      reply_src_port;
   logic [trct_pkg::PORT_W-1:0]      reply_dest_port;
   logic [trct_pkg::NODE_W-1:0]      reply_node;
   logic [trct_pkg::SEQ_W-1:0]       ack_number;
   logic [trct_pkg::SLOT_W-1:0]      slot_used;
   logic [trct_pkg::STATUS_W-1:0]    status;
   logic [trct_pkg::CNT_W-1:0]       granted_bytes;
   logic [trct_pkg::LINK_W-1:0]      conn_state;

   modport source (output valid, reply_kind, reply_src_port, reply_dest_port, reply_node,
                   ack_number, slot_used, status, granted_bytes, conn_state,
                   input ready);
   modport sink   (input valid, reply_kind, reply_src_port, reply_dest_port, reply_node,
                   ack_number, slot_used, status, granted_bytes, conn_state,
                   output ready);
endinterface

### design/trct_ram.sv
// trct_ram: generic single write port, single read port ram with registered read
// no dependencies

module trct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/trct_match.sv
// trct_match: slot valid bits and server ports with a parallel port compare
// registers the match and free vectors, then picks the lowest set entry
// depends on trct_pkg

module trct_match #(
   parameter int SLOTS = trct_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmp_en,
   input  logic [trct_pkg::PORT_W-1:0] cmp_port,
   input  logic                        set_en,
   input  logic [IDX_W-1:0]            set_idx,
   input  logic [trct_pkg::PORT_W-1:0] set_port,
   input  logic                        clr_en,
   input  logic [IDX_W-1:0]            clr_idx,
   output logic                        hit_found,
   output logic [IDX_W-1:0]            hit_idx,
   output logic                        free_found,
   output logic [IDX_W-1:0]            free_idx,
   output logic [SLOTS-1:0]            valid_vec
);

   logic [SLOTS-1:0]                valid_ff;
   logic [trct_pkg::PORT_W-1:0]     port_ff [SLOTS];
   logic [SLOTS-1:0]                match_in;
   logic [SLOTS-1:0]                match_ff;
   logic [SLOTS-1:0]                free_ff;

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (set_en) begin
            valid_ff[set_idx] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
      end
   end

   // server port per slot
   always_ff @(posedge clock) begin
      if (set_en) begin
         port_ff[set_idx] <= set_port;
      end
   end

   // compare every slot against the incoming port
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = valid_ff[i] && (port_ff[i] == cmp_port);
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         match_ff <= match_in;
         free_ff  <= ~valid_ff;
      end
   end

   // lowest matching slot
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_found = 1'b1;
            hit_idx   = IDX_W'(i);
         end
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign valid_vec = valid_ff;

endmodule

### design/transport_receive_conn_table.sv
// transport_receive_conn_table: server-side receive engine over a connection slot table
// depends on trct_pkg, trct_if, trct_match, trct_ram
//
// Usage
//   req_chan carries one command per transfer: open a slot on a server port, deliver an
//   arriving segment (SYN, FIN, DATA), consume buffered bytes, or close a slot.
//   rsp_chan returns exactly one result per command: reply kind and addressing for the
//   answer segment, ack number, the slot used, a status code, granted bytes and the
//   slot's link state afterwards.
// Timing
//   Each command runs in steps: the transfer cycle compares the port against all
//   slots, the next cycle picks the lowest hit or free slot and reads its record from
//   the record ram, and the update stage updates the record and loads the output
//   register. A new command is taken once the previous one has left the update
//   stage, while its result may still sit in the output register.
// Reset
//   Synchronous, active high. All slots become free; record contents are left as is
//   and only used for slots that were opened. No clearing pass is needed.
// Stalls
//   If rsp_chan is not ready while the output register is full, the update stage
//   waits with the record read held; no command is taken in that time.

module transport_receive_conn_table #(
   parameter int SLOTS        = trct_pkg::SLOTS_DEFAULT,
   parameter int BUFFER_BYTES = trct_pkg::BUFFER_BYTES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   trct_req_if.sink    req_chan,
   trct_rsp_if.source  rsp_chan
);

   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BUF_W    = $clog2(BUFFER_BYTES);
   localparam int MAX_W    = (BUF_W > trct_pkg::CNT_W) ? BUF_W : trct_pkg::CNT_W;
   localparam int SUM_W    = MAX_W + 1;
   localparam int EXP_LSB  = BUF_W;
   localparam int LINK_LSB = EXP_LSB + trct_pkg::SEQ_W;
   localparam int NODE_LSB = LINK_LSB + trct_pkg::LINK_W;
   localparam int CP_LSB   = NODE_LSB + trct_pkg::NODE_W;
   localparam int REC_W    = CP_LSB + trct_pkg::PORT_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_MODIFY = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // captured command
   logic [trct_pkg::CMD_W-1:0]    cmd_ff;
   logic [trct_pkg::SLOT_W-1:0]   slot_ff;
   logic [trct_pkg::PORT_W-1:0]   lport_ff;
   logic [trct_pkg::PORT_W-1:0]   rport_ff;
   logic [trct_pkg::NODE_W-1:0]   node_ff;
   logic [trct_pkg::KIND_W-1:0]   kind_ff;
   logic [trct_pkg::SEQ_W-1:0]    seq_ff;
   logic [trct_pkg::CNT_W-1:0]    cnt_ff;

   // lookup result
   logic                          lk_ok;
   logic [IDX_W-1:0]              lk_idx;
   logic                          tgt_ok_ff;
   logic [IDX_W-1:0]              tgt_idx_ff;
   logic [IDX_W-1:0]              slot_idx;
   logic                          slot_in_range;

   // match unit
   logic                          req_xfer;
   logic                          hit_found;
   logic [IDX_W-1:0]              hit_idx;
   logic                          free_found;
   logic [IDX_W-1:0]              free_idx;
   logic [SLOTS-1:0]              valid_vec;
   logic                          set_en;
   logic                          clr_en;

   // record ram
   logic                          ram_rd_en;
   logic                          ram_wr_en;
   logic [REC_W-1:0]              ram_rd_data;
   logic [REC_W-1:0]              ram_wr_data;

   // decoded record and its update
   logic [trct_pkg::PORT_W-1:0]   rec_cport;
   logic [trct_pkg::NODE_W-1:0]   rec_node;
   logic [trct_pkg::LINK_W-1:0]   rec_link;
   logic [trct_pkg::SEQ_W-1:0]    rec_exp;
   logic [BUF_W-1:0]              rec_buf;
   logic [trct_pkg::PORT_W-1:0]   new_cport;
   logic [trct_pkg::NODE_W-1:0]   new_node;
   logic [trct_pkg::LINK_W-1:0]   new_link;
   logic [trct_pkg::SEQ_W-1:0]    new_exp;
   logic [BUF_W-1:0]              new_buf;
   logic [SUM_W-1:0]              buf_sum;
   logic [MAX_W-1:0]              grant;
   logic                          out_free;
   logic                          fire;

   // result being built
   logic [trct_pkg::REPLY_W-1:0]  res_kind;
   logic [trct_pkg::PORT_W-1:0]   res_src;
   logic [trct_pkg::PORT_W-1:0]   res_dest;
   logic [trct_pkg::NODE_W-1:0]   res_node;
   logic [trct_pkg::SEQ_W-1:0]    res_ack;
   logic [trct_pkg::SLOT_W-1:0]   res_slot;
   logic [trct_pkg::STATUS_W-1:0] res_status;
   logic [trct_pkg::CNT_W-1:0]    res_grant;
   logic [trct_pkg::LINK_W-1:0]   res_link;

   // output register
   logic                          rsp_valid_ff;
   logic [trct_pkg::REPLY_W-1:0]  rsp_kind_ff;
   logic [trct_pkg::PORT_W-1:0]   rsp_src_ff;
   logic [trct_pkg::PORT_W-1:0]   rsp_dest_ff;
   logic [trct_pkg::NODE_W-1:0]   rsp_node_ff;
   logic [trct_pkg::SEQ_W-1:0]    rsp_ack_ff;
   logic [trct_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [trct_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [trct_pkg::CNT_W-1:0]    rsp_grant_ff;
   logic [trct_pkg::LINK_W-1:0]   rsp_link_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = (state_ff == ST_MODIFY) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the command on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_chan.cmd;
         slot_ff  <= req_chan.slot;
         lport_ff <= req_chan.local_port;
         rport_ff <= req_chan.remote_port;
         node_ff  <= req_chan.source_node;
         kind_ff  <= req_chan.segment_kind;
         seq_ff   <= req_chan.sequence_req;
         cnt_ff   <= req_chan.byte_count;
      end
   end

   trct_match #(
      .SLOTS (SLOTS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cmp_en     (req_xfer),
      .cmp_port   (req_chan.local_port),
      .set_en     (set_en),
      .set_idx    (tgt_idx_ff),
      .set_port   (lport_ff),
      .clr_en     (clr_en),
      .clr_idx    (tgt_idx_ff),
      .hit_found  (hit_found),
      .hit_idx    (hit_idx),
      .free_found (free_found),
      .free_idx   (free_idx),
      .valid_vec  (valid_vec)
   );

   // pick the target slot for this command
   assign slot_idx      = IDX_W'(slot_ff);
   assign slot_in_range = 32'(slot_ff) < 32'(SLOTS);

   always_comb begin
      case (cmd_ff)
         trct_pkg::CMD_OPEN: begin
            lk_idx = free_idx;
            lk_ok  = free_found;
         end
         trct_pkg::CMD_SEGMENT: begin
            lk_idx = hit_idx;
            lk_ok  = hit_found && (kind_ff != trct_pkg::SEG_OTHER);
         end
         default: begin
            lk_idx = slot_idx;
            lk_ok  = slot_in_range ? valid_vec[slot_idx] : 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         tgt_idx_ff <= lk_idx;
         tgt_ok_ff  <= lk_ok;
      end
   end

   assign ram_rd_en = (state_ff == ST_LOOKUP);

   trct_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tgt_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (lk_idx),
      .rd_data (ram_rd_data)
   );

   // record fields
   assign rec_buf   = ram_rd_data[BUF_W-1:0];
   assign rec_exp   = ram_rd_data[EXP_LSB +: trct_pkg::SEQ_W];
   assign rec_link  = ram_rd_data[LINK_LSB +: trct_pkg::LINK_W];
   assign rec_node  = ram_rd_data[NODE_LSB +: trct_pkg::NODE_W];
   assign rec_cport = ram_rd_data[CP_LSB +: trct_pkg::PORT_W];

   assign buf_sum = SUM_W'(rec_buf) + SUM_W'(cnt_ff);
   assign grant   = (MAX_W'(rec_buf) < MAX_W'(cnt_ff)) ? MAX_W'(rec_buf) : MAX_W'(cnt_ff);

   // read-modify-write of the slot record and result assembly
   always_comb begin
      new_cport  = rec_cport;
      new_node   = rec_node;
      new_link   = rec_link;
      new_exp    = rec_exp;
      new_buf    = rec_buf;
      ram_wr_en  = 1'b0;
      set_en     = 1'b0;
      clr_en     = 1'b0;
      res_kind   = trct_pkg::RK_NONE;
      res_src    = '0;
      res_dest   = '0;
      res_node   = '0;
      res_ack    = '0;
      res_slot   = '0;
      res_status = trct_pkg::STAT_OK;
      res_grant  = '0;
      res_link   = trct_pkg::LINK_CLOSED;
      case (cmd_ff)
         trct_pkg::CMD_OPEN: begin
            if (!tgt_ok_ff) begin
               res_status = trct_pkg::STAT_TABLE_FULL;
            end else begin
               new_cport = '0;
               new_node  = '0;
               new_link  = trct_pkg::LINK_CLOSED;
               new_exp   = '0;
               new_buf   = '0;
               ram_wr_en = fire;
               set_en    = fire;
               res_slot  = trct_pkg::SLOT_W'(tgt_idx_ff);
            end
         end
         trct_pkg::CMD_SEGMENT: begin
            // other segment kinds are ignored outright
            if (kind_ff != trct_pkg::SEG_OTHER) begin
               if (!tgt_ok_ff) begin
                  res_status = trct_pkg::STAT_NO_MATCH;
               end else begin
                  ram_wr_en = fire;
                  res_slot  = trct_pkg::SLOT_W'(tgt_idx_ff);
                  case (kind_ff)
                     trct_pkg::SEG_SYN: begin
                        new_cport = rport_ff;
                        new_node  = node_ff;
                        new_link  = trct_pkg::LINK_CONNECTED;
                        res_kind  = trct_pkg::RK_SYNACK;
                        res_ack   = seq_ff + 32'd1;
                     end
                     trct_pkg::SEG_FIN: begin
                        new_link = trct_pkg::LINK_CLOSE_WAIT;
                        res_kind = trct_pkg::RK_FINACK;
                        res_ack  = seq_ff + 32'd1;
                     end
                     default: begin
                        res_kind = trct_pkg::RK_DATAACK;
                        if (seq_ff != rec_exp) begin
                           res_status = trct_pkg::STAT_OUT_OF_ORDER;
                        end else if (buf_sum >= SUM_W'(BUFFER_BYTES)) begin
                           res_status = trct_pkg::STAT_BUF_FULL;
                        end else begin
                           new_exp = seq_ff + trct_pkg::SEQ_W'(cnt_ff);
                           new_buf = BUF_W'(buf_sum);
                        end
                        res_ack = new_exp;
                     end
                  endcase
                  res_src  = lport_ff;
                  res_dest = new_cport;
                  res_node = new_node;
                  res_link = new_link;
               end
            end
         end
         trct_pkg::CMD_CONSUME: begin
            if (!tgt_ok_ff) begin
               res_status = trct_pkg::STAT_SLOT_EMPTY;
            end else begin
               new_buf   = BUF_W'(MAX_W'(rec_buf) - grant);
               ram_wr_en = fire;
               res_grant = trct_pkg::CNT_W'(grant);
               res_slot  = trct_pkg::SLOT_W'(tgt_idx_ff);
               res_link  = rec_link;
            end
         end
         default: begin
            // close frees the slot only from close-wait
            if (!tgt_ok_ff) begin
               res_status = trct_pkg::STAT_SLOT_EMPTY;
            end else begin
               res_slot = trct_pkg::SLOT_W'(tgt_idx_ff);
               if (rec_link != trct_pkg::LINK_CLOSE_WAIT) begin
                  res_status = trct_pkg::STAT_NOT_CLOSE_WAIT;
                  res_link   = rec_link;
               end else begin
                  clr_en = fire;
               end
            end
         end
      endcase
   end

   assign ram_wr_data = {new_cport, new_node, new_link, new_exp, new_buf};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff   <= res_kind;
         rsp_src_ff    <= res_src;
         rsp_dest_ff   <= res_dest;
         rsp_node_ff   <= res_node;
         rsp_ack_ff    <= res_ack;
         rsp_slot_ff   <= res_slot;
         rsp_status_ff <= res_status;
         rsp_grant_ff  <= res_grant;
         rsp_link_ff   <= res_link;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.reply_kind      = rsp_kind_ff;
   assign rsp_chan.reply_src_port  = rsp_src_ff;
   assign rsp_chan.reply_dest_port = rsp_dest_ff;
   assign rsp_chan.reply_node      = rsp_node_ff;
   assign rsp_chan.ack_number      = rsp_ack_ff;
   assign rsp_chan.slot_used       = rsp_slot_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_bytes   = rsp_grant_ff;
   assign rsp_chan.conn_state      = rsp_link_ff;

   // a result only appears after the update stage
   a_rsp_from_modify: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MODIFY))
      else $error("result appeared without an update stage");

   // a command transfer always starts the lookup
   a_xfer_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_LOOKUP))
      else $error("command transfer did not start a lookup");

   // a reply segment only comes with ok, buffer full or out of order status
   a_reply_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != trct_pkg::RK_NONE) |->
         (rsp_status_ff == trct_pkg::STAT_OK) ||
         (rsp_status_ff == trct_pkg::STAT_BUF_FULL) ||
         (rsp_status_ff == trct_pkg::STAT_OUT_OF_ORDER))
      else $error("reply segment with an error status");

   // granted bytes only from a successful consume
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_grant_ff != '0) |->
         (rsp_status_ff == trct_pkg::STAT_OK) && (rsp_kind_ff == trct_pkg::RK_NONE))
      else $error("bytes granted outside a consume");

endmodule
